// ===== rtl/epr_pkg.sv =====
// Package: shared types and constants of the edge partition router.
package epr_pkg;
	localparam int MAX_MACHINES = 16;
	localparam int MAX_GPUS = 16;
	localparam int TARGET_DEPTH = 1024;
	localparam int MW = $clog2(MAX_MACHINES);
	localparam int TW = $clog2(TARGET_DEPTH);
	localparam int FW = $clog2(TARGET_DEPTH + 1);
	localparam int IDW = 48;
	localparam int PW = 8;
	localparam int CW = 32;
	localparam int NPART = 256;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_BOUND = 2'd1;
	localparam logic [1:0] CMD_TARGET = 2'd2;
	localparam logic [1:0] CMD_EDGE = 2'd3;

	localparam logic [1:0] REG_MACHINES = 2'd0;
	localparam logic [1:0] REG_GPUS = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BOUND,
		ST_MOD,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_INSERT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic bound_wr;
		logic bound_clr;
		logic mod_start;
		logic scan_start;
		logic scan_step;
		logic insert;
		logic cnt_clr_step;
		logic cnt_rd;
		logic cnt_wr;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic mod_done;
		logic range_hit;
		logic scan_done;
		logic scan_hit;
		logic clr_done;
		logic out_busy;
	} sts_t;
endpackage

// ===== rtl/epr_ctrl.sv =====
// Controller: state machine that sequences each item through the datapath.
module epr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  epr_pkg::sts_t sts,
	output epr_pkg::ctl_t ctl
);
	epr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= epr_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_stall = 1'b1;
		case (state_q)
			epr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d = epr_pkg::ST_BOUND;
				end
			end
			epr_pkg::ST_BOUND: begin
				case (sts.cmd)
					epr_pkg::CMD_CLEAR: begin
						ctl.bound_clr = 1'b1;
						state_d = epr_pkg::ST_CLEAR;
					end
					epr_pkg::CMD_BOUND: begin
						ctl.bound_wr = 1'b1;
						state_d = epr_pkg::ST_IDLE;
					end
					epr_pkg::CMD_TARGET: begin
						ctl.scan_start = 1'b1;
						state_d = epr_pkg::ST_SCAN;
					end
					default: begin
						ctl.mod_start = 1'b1;
						ctl.scan_start = 1'b1;
						state_d = epr_pkg::ST_MOD;
					end
				endcase
			end
			epr_pkg::ST_CLEAR: begin
				ctl.cnt_clr_step = 1'b1;
				if (sts.clr_done) state_d = epr_pkg::ST_IDLE;
			end
			epr_pkg::ST_MOD: begin
				if (sts.mod_done) begin
					if (sts.range_hit) state_d = epr_pkg::ST_CNT_RD;
					else state_d = epr_pkg::ST_SCAN;
				end
			end
			epr_pkg::ST_SCAN: begin
				ctl.scan_step = 1'b1;
				state_d = epr_pkg::ST_SCAN_WAIT;
			end
			epr_pkg::ST_SCAN_WAIT: begin
				if (sts.scan_hit || sts.scan_done) begin
					if (sts.cmd == epr_pkg::CMD_TARGET) state_d = epr_pkg::ST_INSERT;
					else state_d = epr_pkg::ST_CNT_RD;
				end else begin
					state_d = epr_pkg::ST_SCAN;
				end
			end
			epr_pkg::ST_INSERT: begin
				ctl.insert = 1'b1;
				state_d = epr_pkg::ST_IDLE;
			end
			epr_pkg::ST_CNT_RD: begin
				ctl.cnt_rd = 1'b1;
				state_d = epr_pkg::ST_CNT_WR;
			end
			epr_pkg::ST_CNT_WR: begin
				if (!sts.out_busy) begin
					ctl.cnt_wr = 1'b1;
					ctl.out_load = 1'b1;
					state_d = epr_pkg::ST_IDLE;
				end
			end
			default: state_d = epr_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/epr_datapath.sv =====
// Datapath: boundary compare, modulo unit, table scan, counters, output register.
module epr_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic [1:0] cmd,
	input  logic [3:0] slot,
	input  logic [47:0] node_id,
	input  logic [47:0] dst_id,
	input  logic [7:0] target_part,
	input  epr_pkg::ctl_t ctl,
	output epr_pkg::sts_t sts,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] part_id,
	output logic [47:0] src_out,
	output logic [47:0] dst_out,
	output logic [31:0] slot_offset,
	output logic from_table,
	output logic not_found
);
	localparam int MCW = $clog2(epr_pkg::MAX_MACHINES + 1);
	localparam int GCW = $clog2(epr_pkg::MAX_GPUS + 1);

	logic [4:0] mach_cnt_q, gpus_q;
	logic [1:0] cmd_q;
	logic [3:0] slot_q;
	logic [47:0] nid_q, dst_q;
	logic [7:0] tpart_q;
	logic [47:0] bounds_q [epr_pkg::MAX_MACHINES];

	logic [MCW-1:0] mc;
	logic [GCW-1:0] gp;
	always_comb begin
		if (mach_cnt_q == 5'd0) mc = MCW'(1);
		else if (32'(mach_cnt_q) > epr_pkg::MAX_MACHINES) mc = MCW'(epr_pkg::MAX_MACHINES);
		else mc = MCW'(mach_cnt_q);
		if (gpus_q == 5'd0) gp = GCW'(1);
		else if (32'(gpus_q) > epr_pkg::MAX_GPUS) gp = GCW'(epr_pkg::MAX_GPUS);
		else gp = GCW'(gpus_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mach_cnt_q <= 5'd1;
			gpus_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_index == epr_pkg::REG_MACHINES) mach_cnt_q <= cfg_data;
			else if (cfg_index == epr_pkg::REG_GPUS) gpus_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cmd;
			slot_q <= slot;
			nid_q <= node_id;
			dst_q <= dst_id;
			tpart_q <= target_part;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < epr_pkg::MAX_MACHINES; i++) bounds_q[i] <= '0;
		end else if (ctl.bound_clr) begin
			for (int i = 0; i < epr_pkg::MAX_MACHINES; i++) bounds_q[i] <= '0;
		end else if (ctl.bound_wr) begin
			bounds_q[slot_q[epr_pkg::MW-1:0]] <= nid_q;
		end
	end

	// priority search over boundaries
	logic rng_hit;
	logic [epr_pkg::MW-1:0] rng_m;
	always_comb begin
		rng_hit = 1'b0;
		rng_m = '0;
		for (int i = epr_pkg::MAX_MACHINES - 1; i >= 0; i--) begin
			if (MCW'(i) < mc && nid_q < bounds_q[i]) begin
				rng_hit = 1'b1;
				rng_m = epr_pkg::MW'(i);
			end
		end
	end

	// restoring modulo, one quotient bit per cycle
	logic [47:0] rem_q;
	logic [5:0] mbit_q;
	logic mod_busy_q, rhit_q;
	logic [epr_pkg::MW-1:0] rm_q;
	logic [GCW+47:0] trial;
	assign trial = (GCW+48)'(gp) << mbit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
			mbit_q <= '0;
			rem_q <= '0;
			rhit_q <= 1'b0;
			rm_q <= '0;
		end else if (ctl.mod_start) begin
			mod_busy_q <= 1'b1;
			mbit_q <= 6'd47;
			rem_q <= nid_q;
			rhit_q <= rng_hit;
			rm_q <= rng_m;
		end else if (mod_busy_q) begin
			if ({{GCW{1'b0}}, rem_q} >= trial) rem_q <= rem_q - trial[47:0];
			if (mbit_q == 6'd0) mod_busy_q <= 1'b0;
			else mbit_q <= mbit_q - 6'd1;
		end
	end
	logic mod_done;
	assign mod_done = mod_busy_q && mbit_q == 6'd0;

	// target table, linear scan
	logic [47:0] tid_mem [epr_pkg::TARGET_DEPTH];
	logic [7:0] tpt_mem [epr_pkg::TARGET_DEPTH];
	logic [47:0] tid_rd_s1;
	logic [7:0] tpt_rd_s1;
	logic [epr_pkg::FW-1:0] fill_q, scan_q;
	logic rd_v_s1;

	always_ff @(posedge clk) begin
		if (ctl.insert && fill_q < epr_pkg::FW'(epr_pkg::TARGET_DEPTH) && !sts.scan_hit) begin
			tid_mem[fill_q[epr_pkg::TW-1:0]] <= nid_q;
			tpt_mem[fill_q[epr_pkg::TW-1:0]] <= tpart_q;
		end
		if (ctl.scan_step) begin
			tid_rd_s1 <= tid_mem[scan_q[epr_pkg::TW-1:0]];
			tpt_rd_s1 <= tpt_mem[scan_q[epr_pkg::TW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			scan_q <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			if (ctl.bound_clr) fill_q <= '0;
			else if (ctl.insert && fill_q < epr_pkg::FW'(epr_pkg::TARGET_DEPTH) && !sts.scan_hit)
				fill_q <= fill_q + epr_pkg::FW'(1);
			if (ctl.scan_start) scan_q <= '0;
			else if (ctl.scan_step && scan_q < fill_q) scan_q <= scan_q + epr_pkg::FW'(1);
			if (ctl.scan_start) rd_v_s1 <= 1'b0;
			else if (ctl.scan_step) rd_v_s1 <= scan_q < fill_q;
		end
	end

	logic scan_hit;
	assign scan_hit = rd_v_s1 && tid_rd_s1 == nid_q;

	// partition select
	logic [7:0] part_sel;
	logic [15:0] prod;
	assign prod = 16'(rm_q) * 16'(gp);
	always_comb begin
		if (rhit_q) part_sel = prod[7:0] + rem_q[7:0];
		else if (scan_hit) part_sel = tpt_rd_s1;
		else part_sel = '0;
	end

	// per-partition counters
	logic [31:0] cnt_mem [epr_pkg::NPART];
	logic [31:0] cnt_rd_s1;
	logic [7:0] part_q, clr_q;
	logic hit_q, miss_q;
	logic clr_busy_q;
	always_ff @(posedge clk) begin
		if (clr_busy_q || ctl.cnt_clr_step) cnt_mem[clr_q] <= '0;
		else if (ctl.cnt_wr && cnt_rd_s1 != 32'hFFFF_FFFF) cnt_mem[part_q] <= cnt_rd_s1 + 32'd1;
		if (ctl.cnt_rd) begin
			cnt_rd_s1 <= cnt_mem[part_sel];
			part_q <= part_sel;
			hit_q <= !rhit_q && scan_hit;
			miss_q <= !rhit_q && !scan_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q || ctl.cnt_clr_step) begin
			clr_q <= clr_q + 8'd1;
			if (clr_q == 8'hFF) clr_busy_q <= 1'b0;
			else clr_busy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ctl.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			part_id <= part_q;
			src_out <= nid_q;
			dst_out <= dst_q;
			slot_offset <= cnt_rd_s1;
			from_table <= hit_q;
			not_found <= miss_q;
		end
	end

	assign sts.cmd = cmd_q;
	assign sts.mod_done = mod_done;
	assign sts.range_hit = rhit_q;
	assign sts.scan_done = !rd_v_s1 && scan_q >= fill_q;
	assign sts.scan_hit = scan_hit;
	assign sts.clr_done = clr_q == 8'hFF;
	assign sts.out_busy = out_valid && out_stall;
endmodule

// ===== rtl/edge_partition_router.sv =====
// Top level: edge partition router.
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | cmd slot node_id dst_id target_part
// out     | out_valid | out_stall | part_id src_out dst_out slot_offset from_table not_found
// Boundary load writes the slot's boundary directly; an edge in range uses the 48-step modulo unit.
// Target load scans the stored targets until a match or the end of the table, then inserts.
// Edge beyond every boundary: runs the modulo unit, then the table scan.
// Clear and reset run a clearing pass over all 256 counters with input stalled.
// A result held by out_stall stalls the next edge only at its final step.
module edge_partition_router (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [3:0] slot,
	input  logic [47:0] node_id,
	input  logic [47:0] dst_id,
	input  logic [7:0] target_part,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] part_id,
	output logic [47:0] src_out,
	output logic [47:0] dst_out,
	output logic [31:0] slot_offset,
	output logic from_table,
	output logic not_found
);
	epr_pkg::ctl_t ctl;
	epr_pkg::sts_t sts;
	logic ctrl_stall;
	logic boot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else if (sts.clr_done) boot_q <= 1'b0;
	end

	epr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid && !boot_q),
		.in_stall(ctrl_stall), .sts(sts), .ctl(ctl)
	);
	assign in_stall = ctrl_stall || boot_q;

	epr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .slot(slot), .node_id(node_id),
		.dst_id(dst_id), .target_part(target_part), .ctl(ctl), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .part_id(part_id),
		.src_out(src_out), .dst_out(dst_out), .slot_offset(slot_offset),
		.from_table(from_table), .not_found(not_found)
	);
endmodule

// ===== rtl/epr_checker.sv =====
// Checker: port-level properties of the edge partition router, with bind.
module epr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic from_table,
	input logic not_found,
	input logic [7:0] part_id
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(part_id)) else $error("held item changed");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(from_table && not_found)) else $error("both flags set");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_found |-> part_id == 8'd0) else $error("miss not in partition 0");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("accepted back to back");
endmodule

bind edge_partition_router epr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .from_table(from_table),
	.not_found(not_found), .part_id(part_id)
);
